// ===== hdl/bhq_pkg.sv =====
`timescale 1ns / 1ps

package bhq_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_NUM_BUCKETS = 12;
   localparam int DEF_COUNT_BITS  = 32;

   // Fixed field widths
   localparam int OP_BITS    = 2;
   localparam int VALUE_BITS = 32;
   localparam int Q_BITS     = 16;
   localparam int QC_BITS    = Q_BITS + 1;
   localparam int QUANT_BITS = 23;
   localparam int OBS_BITS   = 32;
   localparam int SUM_BITS   = 48;
   localparam int PROD_BITS  = QUANT_BITS + QC_BITS;
   localparam int STEP_BITS  = 5;

   // Request codes
   localparam logic [OP_BITS-1:0] OP_OBSERVE  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_QUANTILE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd2;

   // q of all ones stands for exactly 1.0
   localparam logic [Q_BITS-1:0]    Q_CLAMP_CODE = 16'hFFFF;
   localparam logic [QC_BITS-1:0]   Q_ONE        = 17'h10000;
   // last step index of the 17-step multiply and divide loops
   localparam logic [STEP_BITS-1:0] LAST_STEP    = 5'd16;

   // Finite bucket edges in microseconds
   localparam int EDGE_COUNT = 11;
   localparam logic [QUANT_BITS-1:0] EDGE_US [EDGE_COUNT] = '{
      23'd1000, 23'd5000, 23'd10000, 23'd25000, 23'd50000, 23'd100000,
      23'd250000, 23'd500000, 23'd1000000, 23'd2500000, 23'd5000000
   };

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [VALUE_BITS-1:0] value_us;
      logic [Q_BITS-1:0]     quantile_q;
   } req_type;

   typedef struct packed {
      logic [QUANT_BITS-1:0] quantile_us;
      logic [OBS_BITS-1:0]   observation_count;
      logic [SUM_BITS-1:0]   value_sum;
   } rsp_type;

   typedef struct packed {
      logic                  observe;
      logic                  clear;
      logic [VALUE_BITS-1:0] value_us;
   } store_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SCAN,
      ST_MASS,
      ST_NUM,
      ST_DIV,
      ST_PROD,
      ST_FIN,
      ST_DONE
   } state_type;

   // Edges past the table repeat the last one
   function automatic logic [QUANT_BITS-1:0] finite_edge(input int unsigned i);
      logic [QUANT_BITS-1:0] e;
      e = (i < EDGE_COUNT) ? EDGE_US[i] : EDGE_US[EDGE_COUNT-1];
      return e;
   endfunction

endpackage

// ===== hdl/bhq_alu.sv =====
`timescale 1ns / 1ps

module bhq_alu #(
   parameter int WIDTH = bhq_pkg::DEF_COUNT_BITS + bhq_pkg::QC_BITS
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             subtract,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic [WIDTH:0] sum;

   // On subtract the carry out means a >= b
   always_comb begin
      sum    = {1'b0, a} + {1'b0, (subtract ? ~b : b)} + {{WIDTH{1'b0}}, subtract};
      result = sum[WIDTH-1:0];
      carry  = sum[WIDTH];
   end

endmodule

// ===== hdl/bhq_store.sv =====
`timescale 1ns / 1ps

module bhq_store #(
   parameter int NUM_BUCKETS = bhq_pkg::DEF_NUM_BUCKETS,
   parameter int COUNT_BITS  = bhq_pkg::DEF_COUNT_BITS,
   localparam int IDX_BITS   = $clog2(NUM_BUCKETS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bhq_pkg::store_cmd_type        cmd,
   input  logic [IDX_BITS-1:0]           rd_idx,
   output logic [COUNT_BITS-1:0]         rd_data,
   output logic [COUNT_BITS-1:0]         count,
   output logic [bhq_pkg::SUM_BITS-1:0]  sum
);

   logic [COUNT_BITS-1:0]         bucket_ff [NUM_BUCKETS];
   logic [COUNT_BITS-1:0]         bucket_in [NUM_BUCKETS];
   logic [COUNT_BITS-1:0]         count_ff;
   logic [COUNT_BITS-1:0]         count_in;
   logic [bhq_pkg::SUM_BITS-1:0]  sum_ff;
   logic [bhq_pkg::SUM_BITS-1:0]  sum_in;
   logic [bhq_pkg::SUM_BITS:0]    sum_wide;

   always_comb begin
      sum_wide = {1'b0, sum_ff}
               + {{(bhq_pkg::SUM_BITS - bhq_pkg::VALUE_BITS + 1){1'b0}}, cmd.value_us};
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         bucket_in[i] = bucket_ff[i];
         if (cmd.clear) begin
            bucket_in[i] = '0;
         end else if (cmd.observe && (bucket_ff[i] != '1) &&
                      ((i == NUM_BUCKETS - 1) ||
                       (cmd.value_us <= bhq_pkg::VALUE_BITS'(bhq_pkg::finite_edge(i))))) begin
            bucket_in[i] = bucket_ff[i] + 1'b1;
         end
      end
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.clear) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.observe) begin
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
         // saturate the sum on carry out
         sum_in = sum_wide[bhq_pkg::SUM_BITS] ? '1 : sum_wide[bhq_pkg::SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            bucket_ff[i] <= '0;
         end
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            bucket_ff[i] <= bucket_in[i];
         end
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign rd_data = bucket_ff[rd_idx];
   assign count   = count_ff;
   assign sum     = sum_ff;

endmodule

// ===== hdl/bhq_seq.sv =====
`timescale 1ns / 1ps

module bhq_seq #(
   parameter int NUM_BUCKETS = bhq_pkg::DEF_NUM_BUCKETS,
   parameter int COUNT_BITS  = bhq_pkg::DEF_COUNT_BITS,
   localparam int IDX_BITS   = $clog2(NUM_BUCKETS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  bhq_pkg::req_type                req,
   output logic                            busy,
   output logic                            rsp_strobe,
   output logic [bhq_pkg::QUANT_BITS-1:0]  quantile_us,
   output bhq_pkg::store_cmd_type          cmd,
   output logic [IDX_BITS-1:0]             rd_idx,
   input  logic [COUNT_BITS-1:0]           rd_data,
   input  logic [COUNT_BITS-1:0]           count
);

   localparam int W = COUNT_BITS + bhq_pkg::QC_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_BUCKETS - 1);

   bhq_pkg::state_type                state_ff, state_in;

   logic [bhq_pkg::QC_BITS-1:0]       qc_ff, qc_in;
   logic [W-1:0]                      acc_ff, acc_in;     // target = qc * count
   logic [bhq_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic [IDX_BITS-1:0]               idx_ff, idx_in;
   logic [COUNT_BITS-1:0]             prev_ff, prev_in;
   logic [COUNT_BITS-1:0]             cum_ff, cum_in;
   logic [COUNT_BITS-1:0]             mass_ff, mass_in;
   logic [W-1:0]                      num_ff, num_in;
   logic [W-1:0]                      dvs_ff, dvs_in;
   logic [bhq_pkg::QC_BITS-1:0]       f_ff, f_in;
   logic [bhq_pkg::PROD_BITS-1:0]     prod_ff, prod_in;
   logic [bhq_pkg::QUANT_BITS-1:0]    qres_ff, qres_in;

   logic [W-1:0]                      alu_a, alu_b, alu_res;
   logic                              alu_sub, alu_carry;
   logic                              accept;
   logic [IDX_BITS-1:0]               lo_idx;
   logic [bhq_pkg::QUANT_BITS-1:0]    lower, upper, span;
   logic [bhq_pkg::QC_BITS-1:0]       f_clamped;

   bhq_alu #(.WIDTH(W)) u_alu (
      .a        (alu_a),
      .b        (alu_b),
      .subtract (alu_sub),
      .result   (alu_res),
      .carry    (alu_carry)
   );

   assign accept = start && (state_ff == bhq_pkg::ST_IDLE);

   // Bucket edges around the current index
   always_comb begin
      lo_idx    = idx_ff - 1'b1;
      lower     = (idx_ff == '0) ? '0 : bhq_pkg::finite_edge(32'(lo_idx));
      upper     = bhq_pkg::finite_edge(32'(idx_ff));
      span      = upper - lower;
      f_clamped = (f_ff > bhq_pkg::Q_ONE) ? bhq_pkg::Q_ONE : f_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bhq_pkg::ST_IDLE: begin
            if (start) begin
               if ((req.op == bhq_pkg::OP_QUANTILE) && (count != '0)) begin
                  state_in = bhq_pkg::ST_MUL;
               end else begin
                  state_in = bhq_pkg::ST_DONE;
               end
            end
         end
         bhq_pkg::ST_MUL: begin
            if (step_ff == '0) begin
               state_in = bhq_pkg::ST_SCAN;
            end
         end
         bhq_pkg::ST_SCAN: begin
            if (alu_carry && (idx_ff != LAST_IDX)) begin
               state_in = bhq_pkg::ST_MASS;
            end else if (idx_ff == LAST_IDX) begin
               state_in = bhq_pkg::ST_DONE;
            end
         end
         bhq_pkg::ST_MASS: state_in = bhq_pkg::ST_NUM;
         bhq_pkg::ST_NUM: begin
            state_in = (mass_ff == '0) ? bhq_pkg::ST_PROD : bhq_pkg::ST_DIV;
         end
         bhq_pkg::ST_DIV: begin
            if (step_ff == '0) begin
               state_in = bhq_pkg::ST_PROD;
            end
         end
         bhq_pkg::ST_PROD: state_in = bhq_pkg::ST_FIN;
         bhq_pkg::ST_FIN:  state_in = bhq_pkg::ST_DONE;
         bhq_pkg::ST_DONE: state_in = bhq_pkg::ST_IDLE;
         default:          state_in = bhq_pkg::ST_IDLE;
      endcase
   end

   // Outputs and shared unit operands
   always_comb begin
      busy         = (state_ff != bhq_pkg::ST_IDLE);
      rsp_strobe   = (state_ff == bhq_pkg::ST_DONE);
      cmd.observe  = accept && (req.op == bhq_pkg::OP_OBSERVE);
      cmd.clear    = accept && (req.op == bhq_pkg::OP_CLEAR);
      cmd.value_us = req.value_us;
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b0;
      unique case (state_ff)
         bhq_pkg::ST_MUL: begin
            alu_a = {acc_ff[W-2:0], 1'b0};
            alu_b = qc_ff[bhq_pkg::QC_BITS-1] ? W'(count) : '0;
         end
         bhq_pkg::ST_SCAN: begin
            alu_a   = W'({rd_data, 16'b0});
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         bhq_pkg::ST_MASS: begin
            alu_a   = W'(cum_ff);
            alu_b   = W'(prev_ff);
            alu_sub = 1'b1;
         end
         bhq_pkg::ST_NUM: begin
            alu_a   = acc_ff;
            alu_b   = W'({prev_ff, 16'b0});
            alu_sub = 1'b1;
         end
         bhq_pkg::ST_DIV: begin
            alu_a   = num_ff;
            alu_b   = dvs_ff;
            alu_sub = 1'b1;
         end
         bhq_pkg::ST_FIN: begin
            alu_a = W'(lower);
            alu_b = W'(prod_ff[bhq_pkg::PROD_BITS-1:16]);
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // Datapath registers
   always_comb begin
      qc_in   = qc_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      prev_in = prev_ff;
      cum_in  = cum_ff;
      mass_in = mass_ff;
      num_in  = num_ff;
      dvs_in  = dvs_ff;
      f_in    = f_ff;
      prod_in = prod_ff;
      qres_in = qres_ff;
      unique case (state_ff)
         bhq_pkg::ST_IDLE: begin
            if (start) begin
               qc_in   = (req.quantile_q == bhq_pkg::Q_CLAMP_CODE) ? bhq_pkg::Q_ONE
                                                                  : {1'b0, req.quantile_q};
               acc_in  = '0;
               step_in = bhq_pkg::LAST_STEP;
               idx_in  = '0;
               prev_in = '0;
               qres_in = '0;
            end
         end
         bhq_pkg::ST_MUL: begin
            // shift-add, most significant bit of q first
            acc_in  = alu_res;
            qc_in   = {qc_ff[bhq_pkg::QC_BITS-2:0], 1'b0};
            step_in = step_ff - 1'b1;
         end
         bhq_pkg::ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               // unbounded bucket or overshoot: last finite edge
               qres_in = bhq_pkg::finite_edge(32'(NUM_BUCKETS - 2));
            end else if (alu_carry) begin
               cum_in = rd_data;
            end else begin
               prev_in = rd_data;
               idx_in  = idx_ff + 1'b1;
            end
         end
         bhq_pkg::ST_MASS: begin
            mass_in = alu_carry ? alu_res[COUNT_BITS-1:0] : '0;
         end
         bhq_pkg::ST_NUM: begin
            num_in  = alu_carry ? alu_res : '0;
            dvs_in  = W'({mass_ff, 16'b0});
            f_in    = '0;
            step_in = bhq_pkg::LAST_STEP;
         end
         bhq_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (alu_carry) begin
               num_in = alu_res;
            end
            f_in    = {f_ff[bhq_pkg::QC_BITS-2:0], alu_carry};
            dvs_in  = {1'b0, dvs_ff[W-1:1]};
            step_in = step_ff - 1'b1;
         end
         bhq_pkg::ST_PROD: begin
            prod_in = {{bhq_pkg::QC_BITS{1'b0}}, span}
                    * {{bhq_pkg::QUANT_BITS{1'b0}}, f_clamped};
         end
         bhq_pkg::ST_FIN: begin
            qres_in = alu_res[bhq_pkg::QUANT_BITS-1:0];
         end
         default: begin
            qres_in = qres_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bhq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      qc_ff   <= qc_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      cum_ff  <= cum_in;
      mass_ff <= mass_in;
      num_ff  <= num_in;
      dvs_ff  <= dvs_in;
      f_ff    <= f_in;
      prod_ff <= prod_in;
      qres_ff <= qres_in;
   end

   assign rd_idx      = idx_ff;
   assign quantile_us = qres_ff;

`ifndef SYNTHESIS
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_div_mass : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhq_pkg::ST_DIV) |-> (mass_ff != '0))
      else $error("division started with empty bucket mass");

   a_frac_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhq_pkg::ST_PROD) |-> (f_ff <= bhq_pkg::Q_ONE))
      else $error("interpolation fraction above one");

   a_scan_idx : assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhq_pkg::ST_SCAN) |-> (idx_ff <= LAST_IDX))
      else $error("bucket scan ran past the last bucket");
`endif

endmodule

// ===== hdl/bucket_histogram_quantile_top.sv =====
`timescale 1ns / 1ps

// Latency histogram with cumulative buckets and a quantile estimator. A request
// is taken when start is high and busy is low; its single result appears on
// rsp_data for exactly one cycle with rsp_strobe high, and must be captured
// then, as there is no way to hold it. Observe, clear and a query on an empty
// histogram give the strobe in the cycle after the request. A quantile query
// runs its adds and subtracts on one shared unit: 17 shift-add steps form
// q*count, a scan of one bucket per cycle finds the hit bucket, then the mass
// and numerator set-up states, 17 restoring-division steps for the fraction
// (skipped when the bucket holds no mass), a multiply on its own multiplier
// and a final add. busy stays high through the strobe cycle, and the next
// request is taken in the cycle after it.
module bucket_histogram_quantile_top #(
   parameter int NUM_BUCKETS = bhq_pkg::DEF_NUM_BUCKETS,
   parameter int COUNT_BITS  = bhq_pkg::DEF_COUNT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bhq_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output bhq_pkg::rsp_type rsp_data
);

   localparam int IDX_BITS = $clog2(NUM_BUCKETS);

   bhq_pkg::store_cmd_type             cmd;
   logic [IDX_BITS-1:0]                rd_idx;
   logic [COUNT_BITS-1:0]              rd_data;
   logic [COUNT_BITS-1:0]              count;
   logic [bhq_pkg::SUM_BITS-1:0]       sum;
   logic [bhq_pkg::QUANT_BITS-1:0]     quantile_us;
   logic [bhq_pkg::OBS_BITS-1:0]       obs_count;

   bhq_store #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .count   (count),
      .sum     (sum)
   );

   bhq_seq #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_data),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .quantile_us (quantile_us),
      .cmd         (cmd),
      .rd_idx      (rd_idx),
      .rd_data     (rd_data),
      .count       (count)
   );

   // Saturate a wide count to the reported width
   generate
      if (COUNT_BITS > bhq_pkg::OBS_BITS) begin : g_wide_count
         assign obs_count = (count[COUNT_BITS-1:bhq_pkg::OBS_BITS] != '0)
                          ? '1 : count[bhq_pkg::OBS_BITS-1:0];
      end else begin : g_narrow_count
         assign obs_count = bhq_pkg::OBS_BITS'(count);
      end
   endgenerate

   always_comb begin
      rsp_data.quantile_us       = quantile_us;
      rsp_data.observation_count = obs_count;
      rsp_data.value_sum         = sum;
   end

endmodule

// ===== tb/histogram_checker.sv =====
`timescale 1ns / 1ps

module histogram_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  bhq_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  bhq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   localparam int BUCKETS = bhq_pkg::DEF_NUM_BUCKETS;
   localparam logic [bhq_pkg::OBS_BITS-1:0] COUNT_CEIL = '1;
   localparam logic [bhq_pkg::SUM_BITS-1:0] SUM_CEIL   = '1;

   logic [bhq_pkg::OBS_BITS-1:0] bucket_hits [BUCKETS];
   logic [bhq_pkg::OBS_BITS-1:0] obs_total;
   logic [bhq_pkg::SUM_BITS-1:0] sum_total;
   bhq_pkg::rsp_type             awaited_rsps [$];
   int                           errors = 0;

   function automatic void wipe_histogram();
      for (int i = 0; i < BUCKETS; i++) begin
         bucket_hits[i] = '0;
      end
      obs_total = '0;
      sum_total = '0;
   endfunction

   function automatic logic [bhq_pkg::OBS_BITS-1:0] bump(
      input logic [bhq_pkg::OBS_BITS-1:0] c);
      return (c == COUNT_CEIL) ? c : c + 1'b1;
   endfunction

   // target = q*count; compare against cum*2^16 so no fractions are lost
   function automatic logic [bhq_pkg::QUANT_BITS-1:0] estimate_quantile(
      input logic [bhq_pkg::Q_BITS-1:0] q);
      logic [63:0] qc;
      logic [63:0] target;
      logic [63:0] prev;
      logic [63:0] cum;
      logic [63:0] mass;
      logic [63:0] num;
      logic [63:0] frac;
      logic [63:0] lower;
      logic [63:0] upper;
      if (obs_total == 0) return '0;
      qc     = (q == bhq_pkg::Q_CLAMP_CODE) ? 64'(bhq_pkg::Q_ONE) : 64'(q);
      target = qc * 64'(obs_total);
      prev   = 0;
      for (int i = 0; i < BUCKETS; i++) begin
         cum = 64'(bucket_hits[i]);
         if ((cum << 16) >= target) begin
            lower = (i == 0) ? 64'd0 : 64'(bhq_pkg::EDGE_US[i-1]);
            if (i == BUCKETS - 1) return bhq_pkg::QUANT_BITS'(lower);
            upper = 64'(bhq_pkg::EDGE_US[i]);
            mass  = (cum >= prev) ? cum - prev : 64'd0;
            frac  = 0;
            if (mass != 0) begin
               num  = (target >= (prev << 16)) ? target - (prev << 16) : 64'd0;
               frac = num / mass;
               if (frac > 64'd65536) frac = 64'd65536;
            end
            return bhq_pkg::QUANT_BITS'(lower + (((upper - lower) * frac) >> 16));
         end
         prev = cum;
      end
      return bhq_pkg::EDGE_US[BUCKETS-2];
   endfunction

   function automatic bhq_pkg::rsp_type apply_request(input bhq_pkg::req_type r);
      bhq_pkg::rsp_type ans;
      ans = '0;
      case (r.op)
         bhq_pkg::OP_OBSERVE: begin
            for (int i = 0; i < BUCKETS; i++) begin
               if (i == BUCKETS - 1 || r.value_us <= 32'(bhq_pkg::EDGE_US[i])) begin
                  bucket_hits[i] = bump(bucket_hits[i]);
               end
            end
            obs_total = bump(obs_total);
            if (SUM_CEIL - sum_total < bhq_pkg::SUM_BITS'(r.value_us)) begin
               sum_total = SUM_CEIL;
            end else begin
               sum_total = sum_total + bhq_pkg::SUM_BITS'(r.value_us);
            end
         end
         bhq_pkg::OP_QUANTILE: begin
            ans.quantile_us = estimate_quantile(r.quantile_q);
         end
         bhq_pkg::OP_CLEAR: begin
            wipe_histogram();
         end
         default: begin
         end
      endcase
      ans.observation_count = obs_total;
      ans.value_sum         = sum_total;
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      bhq_pkg::rsp_type want;
      if (reset) begin
         wipe_histogram();
         awaited_rsps.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_rsps.size() == 0) begin
               $error("result strobe with no request outstanding");
               errors++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_data.quantile_us !== want.quantile_us) begin
                  $error("quantile_us: expected %0d, actual %0d",
                         want.quantile_us, rsp_data.quantile_us);
                  errors++;
               end
               if (rsp_data.observation_count !== want.observation_count) begin
                  $error("observation_count: expected %0d, actual %0d",
                         want.observation_count, rsp_data.observation_count);
                  errors++;
               end
               if (rsp_data.value_sum !== want.value_sum) begin
                  $error("value_sum: expected %0d, actual %0d",
                         want.value_sum, rsp_data.value_sum);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            awaited_rsps.insert(awaited_rsps.size(), apply_request(req_data));
         end
      end
      pending    <= awaited_rsps.size();
      fail_count <= errors;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam logic [bhq_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 600;

   logic             clock;
   logic             reset;
   logic             start;
   bhq_pkg::req_type req_data;
   logic             busy;
   logic             rsp_strobe;
   bhq_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   int               cycle_count = 0;

   bucket_histogram_quantile_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   histogram_checker histogram_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("bucket_histogram_quantile_top regression: fail");
      $finish;
   end

   // Hold start high until the block takes the request
   task automatic issue(input logic [bhq_pkg::OP_BITS-1:0]    op,
                        input logic [bhq_pkg::VALUE_BITS-1:0] value,
                        input logic [bhq_pkg::Q_BITS-1:0]     q,
                        input int                             idle_pct,
                        input bit                             drain);
      bhq_pkg::req_type r;
      r.op         = op;
      r.value_us   = value;
      r.quantile_q = q;
      if (drain) begin
         start <= 1'b0;
         @(posedge clock);
         while (pending != 0) @(posedge clock);
      end else begin
         // idle each cycle with the given odds
         while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [bhq_pkg::OP_BITS-1:0] pick_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return bhq_pkg::OP_OBSERVE;
      if (roll < 95) return bhq_pkg::OP_QUANTILE;
      if (roll < 97) return bhq_pkg::OP_CLEAR;
      return OP_UNUSED;
   endfunction

   // Cluster values on and around the bucket edges
   function automatic logic [bhq_pkg::VALUE_BITS-1:0] pick_value();
      int idx;
      idx = $urandom_range(bhq_pkg::EDGE_COUNT - 1);
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return $urandom_range(1000);
         2, 3:    return 32'(bhq_pkg::EDGE_US[idx]) + $urandom_range(2) - 1;
         4:       return $urandom_range(20000000, 5000001);
         default: return $urandom_range(32'(bhq_pkg::EDGE_US[idx]));
      endcase
   endfunction

   function automatic logic [bhq_pkg::Q_BITS-1:0] pick_q();
      case ($urandom_range(9))
         0:       return '0;
         1:       return bhq_pkg::Q_CLAMP_CODE;
         2:       return bhq_pkg::Q_CLAMP_CODE - 1'b1;
         default: return bhq_pkg::Q_BITS'($urandom_range(65535));
      endcase
   endfunction

   initial begin
      int idle;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty histogram
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'hFFFF_FFFF, bhq_pkg::Q_CLAMP_CODE, 0, 1'b0);
      issue(bhq_pkg::OP_OBSERVE, 32'd0, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, bhq_pkg::Q_CLAMP_CODE, 0, 1'b0);
      issue(bhq_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0);
      // unbounded bucket, then interpolation in the first one
      issue(bhq_pkg::OP_QUANTILE, 32'd0, bhq_pkg::Q_CLAMP_CODE, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'h8000, 0, 1'b0);
      issue(bhq_pkg::OP_OBSERVE, 32'd1000, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_OBSERVE, 32'd1001, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_OBSERVE, 32'd5000000, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_OBSERVE, 32'd5000001, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'hFFFE, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'h0001, 0, 1'b0);
      issue(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0);
      issue(bhq_pkg::OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'h8000, 0, 1'b0);
      // first bucket holds no mass
      issue(bhq_pkg::OP_OBSERVE, 32'd2000000, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'h0000, 0, 1'b0);
      issue(bhq_pkg::OP_QUANTILE, 32'd0, 16'h7FFF, 0, 1'b0);
      issue(bhq_pkg::OP_CLEAR, 32'd0, 16'h0000, 0, 1'b0);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle = (n < 200) ? 36 : (n < 400) ? 86 : 0;
         issue(pick_op(), pick_value(), pick_q(), idle, n == 300 || n == 500);
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("bucket_histogram_quantile_top regression: pass");
      end else begin
         $display("bucket_histogram_quantile_top regression: fail");
      end
      $finish;
   end

endmodule
